[hdl/gic_pkg.sv]
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants for the gamepad input conditioner
// Register indexes, reset values and the divider and square root request/response beats.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int unsigned NUM_REGS = 6;

    typedef enum logic [2:0] {
        REG_LEFT_DZ      = 3'd0,
        REG_RIGHT_DZ     = 3'd1,
        REG_PRESS_LEVEL  = 3'd2,
        REG_RELEASE_LVL  = 3'd3,
        REG_FULL_SCALE   = 3'd4,
        REG_Y_KEEP_SIGN  = 3'd5
    } reg_idx_t;

    localparam logic [14:0] LEFT_DZ_RESET     = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET    = 15'd8689;
    localparam logic [7:0]  PRESS_RESET       = 8'd30;
    localparam logic [7:0]  RELEASE_RESET     = 8'd20;
    localparam logic [14:0] FULL_SCALE_RESET  = 15'd32767;

    localparam logic [16:0] ONE_Q15 = 17'd65536 >> 1;

    // Divider: quotient width, operand width
    localparam int unsigned DIV_W = 48;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
    } div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [47:0]       radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [23:0]       root;
    } sqrt_rsp_t;

endpackage

[hdl/gic_divider.sv]
// ----------------------------------------------------------------------------
// gic_divider: bit-serial restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module gic_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  gic_pkg::div_req_t req,
    output gic_pkg::div_rsp_t rsp
);

    localparam int unsigned W = gic_pkg::DIV_W;

    logic [W-1:0]   quo_reg;
    logic [W:0]     rem_reg;
    logic [W-1:0]   den_reg;
    logic [5:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     trial;

    // Shift in the next numerator bit and trial-subtract
    assign trial = {rem_reg[W-1:0], quo_reg[W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-1:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

[hdl/gic_sqrt.sv]
// ----------------------------------------------------------------------------
// gic_sqrt: digit-serial integer square root
// Two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gic_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  gic_pkg::sqrt_req_t req,
    output gic_pkg::sqrt_rsp_t rsp
);

    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [25:0] shifted;
    logic [25:0] trial;

    // Bring down two bits, test against 4*root+1
    assign shifted = {rem_reg[23:0], rad_reg[47:46]};
    assign trial   = shifted - {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd24;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[45:0], 2'b00};
            if (!trial[25])
            begin
                rem_reg  <= trial;
                root_reg <= {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

[hdl/gamepad_input_conditioner_core.sv]
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_core: controller poll conditioner
// Buttons, trigger hysteresis and radial stick dead zones per poll.
// ----------------------------------------------------------------------------
// Usage:
//  One poll beat enters on the in_ channel (in_valid/in_ready) and one
//  result beat leaves on the out_ channel (out_valid/out_ready).
//  Registers are to be written by the user over the APB port only while the
//  block is idle; the block itself does not enforce this. One poll is worked
//  at a time. Each poll runs a sequencer over one shared bit-serial divider
//  and one square root unit: two trigger divisions, then per stick four
//  squaring steps, one root, one rate division, two axis divisions and a
//  step on to the next stick. A trigger below its press level or with a
//  press level of 255, a stick inside its dead zone or a full scale at or
//  below the dead zone skips divisions.
//  The result waits in an output register; a new poll is taken while it
//  waits, and work stops before the result stage only if it is still full.
//  Reset clears the button history, both trigger flags and the registers
//  to their reset values; no result is pending after reset.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_core (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // poll
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         connected,
    input  logic [15:0]  button_bits,
    input  logic [7:0]   left_trigger_raw,
    input  logic [7:0]   right_trigger_raw,
    input  logic signed [15:0] left_x_raw,
    input  logic signed [15:0] left_y_raw,
    input  logic signed [15:0] right_x_raw,
    input  logic signed [15:0] right_y_raw,
    // result
    output logic         out_valid,
    input  logic         out_ready,
    output logic [15:0]  buttons_held,
    output logic [15:0]  buttons_pushed,
    output logic [15:0]  buttons_released,
    output logic [5:0]   trigger_flags,
    output logic [15:0]  left_trigger_level,
    output logic [15:0]  right_trigger_level,
    output logic signed [16:0] left_x_out,
    output logic signed [16:0] left_y_out,
    output logic signed [16:0] right_x_out,
    output logic signed [16:0] right_y_out,
    output logic         input_active
);

    localparam int unsigned W = gic_pkg::DIV_W;

    typedef enum logic [3:0] {
        S_IDLE, S_TDIV, S_TWAIT, S_SQ, S_ROOT, S_RWAIT, S_RATE, S_RATEW,
        S_AXIS, S_AXISW, S_NEXT, S_OUT
    } state_t;

    // Configuration registers
    logic [14:0] ldz_reg, rdz_reg, fs_reg;
    logic [7:0]  press_reg, rel_reg;
    logic        yks_reg;
    logic [2:0]  widx;

    assign pready = 1'b1;
    assign widx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldz_reg   <= gic_pkg::LEFT_DZ_RESET;
            rdz_reg   <= gic_pkg::RIGHT_DZ_RESET;
            press_reg <= gic_pkg::PRESS_RESET;
            rel_reg   <= gic_pkg::RELEASE_RESET;
            fs_reg    <= gic_pkg::FULL_SCALE_RESET;
            yks_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                gic_pkg::REG_LEFT_DZ:     ldz_reg   <= pwdata[14:0];
                gic_pkg::REG_RIGHT_DZ:    rdz_reg   <= pwdata[14:0];
                gic_pkg::REG_PRESS_LEVEL: press_reg <= pwdata[7:0];
                gic_pkg::REG_RELEASE_LVL: rel_reg   <= pwdata[7:0];
                gic_pkg::REG_FULL_SCALE:  fs_reg    <= pwdata[14:0];
                gic_pkg::REG_Y_KEEP_SIGN: yks_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            gic_pkg::REG_LEFT_DZ:     prdata = {17'd0, ldz_reg};
            gic_pkg::REG_RIGHT_DZ:    prdata = {17'd0, rdz_reg};
            gic_pkg::REG_PRESS_LEVEL: prdata = {24'd0, press_reg};
            gic_pkg::REG_RELEASE_LVL: prdata = {24'd0, rel_reg};
            gic_pkg::REG_FULL_SCALE:  prdata = {17'd0, fs_reg};
            gic_pkg::REG_Y_KEEP_SIGN: prdata = {31'd0, yks_reg};
            default:                  prdata = '0;
        endcase
    end

    // Work registers
    state_t      state_reg;
    logic [15:0] last_btn_reg;
    logic        lheld_reg, rheld_reg;
    logic        conn_reg;
    logic [15:0] btn_reg;
    logic [7:0]  lt_reg, rt_reg;
    logic signed [15:0] ax_reg [4];
    logic        side_reg;     // 0 left trigger/stick, 1 right
    logic        axsel_reg;    // 0 x, 1 y
    logic [1:0]  sqc_reg;      // squaring step
    logic [32:0] s_reg;
    logic [29:0] dzsq_reg;
    logic [23:0] lq_reg;
    logic [16:0] rate_reg;
    logic        act_reg;
    logic [15:0] tl_reg [2];
    logic signed [16:0] so_reg [4];
    logic        so_zero_reg;

    // Output register
    logic        out_valid_reg;
    logic [15:0] o_held_reg, o_push_reg, o_rel_reg, o_tl_reg, o_tr_reg;
    logic [5:0]  o_flags_reg;
    logic signed [16:0] o_ax_reg [4];
    logic        o_act_reg;

    gic_pkg::div_req_t  dreq;
    gic_pkg::div_rsp_t  drsp;
    gic_pkg::sqrt_req_t qreq;
    gic_pkg::sqrt_rsp_t qrsp;

    gic_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    gic_sqrt    u_sqrt (.clk(clk), .rst_n(rst_n), .req(qreq), .rsp(qrsp));

    // Current-side selections
    logic [14:0] dz;
    logic [7:0]  tv;
    logic signed [15:0] axv;
    logic [15:0] axmag;
    logic [31:0] sqv;
    logic [15:0] fs_m_dz;

    assign dz    = side_reg ? rdz_reg : ldz_reg;
    assign tv    = side_reg ? rt_reg : lt_reg;
    assign axv   = ax_reg[{side_reg, axsel_reg}];
    assign axmag = axv[15] ? 16'(-axv) : 16'(axv);
    assign sqv   = axmag * axmag;
    assign fs_m_dz = {1'b0, fs_reg} - {1'b0, dz};

    // Divider and square root requests by state
    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = 48'd1;
        qreq.start = (state_reg == S_ROOT);
        qreq.radicand = {s_reg[31:0], 16'd0};
        unique case (state_reg)
            S_TDIV:
            begin
                dreq.start = 1'b1;
                dreq.num   = W'({8'(tv - press_reg), 15'd0});
                dreq.den   = W'(9'd255 - {1'b0, press_reg});
            end
            S_RATE:
            begin
                dreq.start = 1'b1;
                dreq.num   = (lq_reg > {1'b0, dz, 8'd0}) ?
                             W'({24'(lq_reg - {1'b0, dz, 8'd0}), 15'd0}) : '0;
                dreq.den   = W'({fs_m_dz[14:0], 8'd0});
            end
            S_AXIS:
            begin
                dreq.start = 1'b1;
                dreq.num   = W'({33'(axmag) * 33'(rate_reg), 8'd0});
                dreq.den   = W'(lq_reg);
            end
            default: ;
        endcase
    end

    // Current poll hysteresis and masks
    logic lnow, rnow;
    logic [15:0] pushed, released;
    assign lnow = lt_reg >= (lheld_reg ? rel_reg : press_reg) && conn_reg;
    assign rnow = rt_reg >= (rheld_reg ? rel_reg : press_reg) && conn_reg;
    assign pushed   = btn_reg & ~last_btn_reg;
    assign released = ~btn_reg & last_btn_reg;

    logic [16:0] yval;
    logic signed [16:0] sq_res;
    assign yval = 17'(drsp.quo);
    assign sq_res = axv[15] ? -$signed(yval) : $signed(yval);

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_btn_reg  <= '0;
            lheld_reg     <= 1'b0;
            rheld_reg     <= 1'b0;
            side_reg      <= 1'b0;
            axsel_reg     <= 1'b0;
            sqc_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_TDIV;
                        side_reg  <= 1'b0;
                        act_reg   <= 1'b0;
                    end
                end
                S_TDIV:
                begin
                    if (tv < press_reg)
                    begin
                        tl_reg[side_reg] <= '0;
                        side_reg <= ~side_reg;
                        if (side_reg)
                        begin
                            state_reg <= S_SQ;
                            sqc_reg <= '0;
                        end
                    end
                    else if (press_reg == 8'd255)
                    begin
                        tl_reg[side_reg] <= 16'(gic_pkg::ONE_Q15);
                        side_reg <= ~side_reg;
                        if (side_reg)
                        begin
                            state_reg <= S_SQ;
                            sqc_reg <= '0;
                        end
                    end
                    else
                        state_reg <= S_TWAIT;
                end
                S_TWAIT:
                begin
                    if (drsp.done)
                    begin
                        tl_reg[side_reg] <= drsp.quo[15:0];
                        side_reg <= ~side_reg;
                        state_reg <= side_reg ? S_SQ : S_TDIV;
                        sqc_reg <= '0;
                    end
                end
                // Square both axes and the dead zone, one product a cycle
                S_SQ:
                begin
                    sqc_reg <= sqc_reg + 2'd1;
                    axsel_reg <= ~axsel_reg;
                    unique case (sqc_reg)
                        2'd0: s_reg <= {1'b0, sqv};
                        2'd1: s_reg <= s_reg + {1'b0, sqv};
                        2'd2: dzsq_reg <= dz * dz;
                        default:
                        begin
                            axsel_reg <= 1'b0;
                            if (s_reg <= {3'd0, dzsq_reg})
                            begin
                                so_zero_reg <= 1'b1;
                                state_reg <= S_NEXT;
                            end
                            else
                            begin
                                so_zero_reg <= 1'b0;
                                act_reg <= 1'b1;
                                state_reg <= S_ROOT;
                            end
                        end
                    endcase
                end
                S_ROOT: state_reg <= S_RWAIT;
                S_RWAIT:
                begin
                    if (qrsp.done)
                    begin
                        lq_reg <= qrsp.root;
                        state_reg <= S_RATE;
                    end
                end
                S_RATE:
                begin
                    if (fs_reg == dz)
                    begin
                        rate_reg <= gic_pkg::ONE_Q15;
                        state_reg <= S_AXIS;
                    end
                    else if (fs_reg < dz)
                    begin
                        rate_reg <= '0;
                        state_reg <= S_AXIS;
                    end
                    else
                        state_reg <= S_RATEW;
                end
                S_RATEW:
                begin
                    if (drsp.done)
                    begin
                        rate_reg <= (drsp.quo > W'(gic_pkg::ONE_Q15)) ?
                                    gic_pkg::ONE_Q15 : drsp.quo[16:0];
                        state_reg <= S_AXIS;
                    end
                end
                S_AXIS: state_reg <= S_AXISW;
                S_AXISW:
                begin
                    if (drsp.done)
                    begin
                        so_reg[{side_reg, axsel_reg}] <= sq_res;
                        axsel_reg <= ~axsel_reg;
                        state_reg <= axsel_reg ? S_NEXT : S_AXIS;
                    end
                end
                S_NEXT:
                begin
                    if (so_zero_reg)
                    begin
                        so_reg[{side_reg, 1'b0}] <= '0;
                        so_reg[{side_reg, 1'b1}] <= '0;
                    end
                    axsel_reg <= 1'b0;
                    sqc_reg <= '0;
                    side_reg <= ~side_reg;
                    state_reg <= side_reg ? S_OUT : S_SQ;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        last_btn_reg  <= btn_reg;
                        lheld_reg     <= lnow;
                        rheld_reg     <= rnow;
                        side_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Capture poll and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            conn_reg  <= connected;
            btn_reg   <= connected ? button_bits : '0;
            lt_reg    <= connected ? left_trigger_raw : '0;
            rt_reg    <= connected ? right_trigger_raw : '0;
            ax_reg[0] <= connected ? left_x_raw : '0;
            ax_reg[1] <= connected ? left_y_raw : '0;
            ax_reg[2] <= connected ? right_x_raw : '0;
            ax_reg[3] <= connected ? right_y_raw : '0;
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            o_held_reg  <= btn_reg;
            o_push_reg  <= pushed;
            o_rel_reg   <= released;
            o_flags_reg <= {~rnow & rheld_reg, rnow & ~rheld_reg, rnow,
                            ~lnow & lheld_reg, lnow & ~lheld_reg, lnow};
            o_tl_reg    <= tl_reg[0];
            o_tr_reg    <= tl_reg[1];
            o_ax_reg[0] <= so_reg[0];
            o_ax_reg[1] <= yks_reg ? so_reg[1] : -so_reg[1];
            o_ax_reg[2] <= so_reg[2];
            o_ax_reg[3] <= yks_reg ? so_reg[3] : -so_reg[3];
            o_act_reg   <= act_reg || (pushed != '0) ||
                           (lt_reg > rel_reg) || (rt_reg > rel_reg);
        end
    end

    assign buttons_held        = o_held_reg;
    assign buttons_pushed      = o_push_reg;
    assign buttons_released    = o_rel_reg;
    assign trigger_flags       = o_flags_reg;
    assign left_trigger_level  = o_tl_reg;
    assign right_trigger_level = o_tr_reg;
    assign left_x_out          = o_ax_reg[0];
    assign left_y_out          = o_ax_reg[1];
    assign right_x_out         = o_ax_reg[2];
    assign right_y_out         = o_ax_reg[3];
    assign input_active        = o_act_reg;

endmodule

[hdl/gic_checker.sv]
// ----------------------------------------------------------------------------
// gic_checker: port-level checks for the gamepad input conditioner
// Watches the result handshake and result fields over time.
// ----------------------------------------------------------------------------
module gic_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] buttons_held,
    input logic [15:0] buttons_pushed,
    input logic [15:0] buttons_released,
    input logic [5:0]  trigger_flags,
    input logic        input_active
);

    // A stalled result beat stays valid with buttons_held stable
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(buttons_held))
        else $error("result beat changed while stalled");

    // Pushed buttons are held
    a_push_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (buttons_pushed & ~buttons_held) == 16'd0)
        else $error("pushed button not held");

    // Released buttons are not held
    a_rel_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (buttons_released & buttons_held) == 16'd0)
        else $error("released button still held");

    // A pushed button means activity
    a_push_act: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buttons_pushed != 16'd0 |-> input_active)
        else $error("push without activity");

    // A trigger cannot be pushed and released together
    a_trig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(trigger_flags[1] && trigger_flags[2]) &&
                      !(trigger_flags[4] && trigger_flags[5]))
        else $error("trigger pushed and released at once");

endmodule

bind gamepad_input_conditioner_core gic_checker u_gic_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_ready(out_ready), .buttons_held(buttons_held),
    .buttons_pushed(buttons_pushed), .buttons_released(buttons_released),
    .trigger_flags(trigger_flags), .input_active(input_active)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: gamepad input conditioner bench
// Polls go in on a valid/ready driver; results are checked in order against
// an in-bench predictor of buttons, trigger hysteresis and radial dead zones.
// Registers are rewritten over APB between idle phases, extremes included.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        conn;
        logic [15:0] btn;
        logic [7:0]  lt;
        logic [7:0]  rt;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
    } poll_t;

    typedef struct packed {
        logic [15:0] held;
        logic [15:0] pushed;
        logic [15:0] released;
        logic [5:0]  flags;
        logic [15:0] ltl;
        logic [15:0] rtl;
        logic [16:0] lxo;
        logic [16:0] lyo;
        logic [16:0] rxo;
        logic [16:0] ryo;
        logic        active;
    } cond_t;

    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    poll_t cur = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    cond_t got;

    // shadow registers and state of the predictor
    logic [14:0] dz_l, dz_r, full_scale;
    logic [7:0]  press_lvl, release_lvl;
    logic        keep_y;
    logic [15:0] prev_btn;
    logic        lt_down, rt_down;

    poll_t polls[$];
    cond_t expected_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int in_gap = 0, out_gap = 0;

    always #2 clk = ~clk;

    gamepad_input_conditioner_core uut (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .in_valid, .in_ready,
        .connected(cur.conn), .button_bits(cur.btn),
        .left_trigger_raw(cur.lt), .right_trigger_raw(cur.rt),
        .left_x_raw(cur.lx), .left_y_raw(cur.ly),
        .right_x_raw(cur.rx), .right_y_raw(cur.ry),
        .out_valid, .out_ready,
        .buttons_held(got.held), .buttons_pushed(got.pushed),
        .buttons_released(got.released), .trigger_flags(got.flags),
        .left_trigger_level(got.ltl), .right_trigger_level(got.rtl),
        .left_x_out(got.lxo), .left_y_out(got.lyo),
        .right_x_out(got.rxo), .right_y_out(got.ryo),
        .input_active(got.active)
    );

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] trigger_level(logic [7:0] v);
        longint unsigned p;
        p = press_lvl;
        if (v < p) return 16'd0;
        if (p >= 255) return 16'h8000;
        return 16'((longint'(v) - p) * 32768 / (255 - p));
    endfunction

    function automatic logic [16:0] scale_axis(longint a, longint unsigned rate,
                                               longint unsigned lq);
        longint unsigned m;
        longint r;
        m = a < 0 ? -a : a;
        r = longint'(m * 256 * rate / lq);
        return 17'(a < 0 ? -r : r);
    endfunction

    task automatic dead_zone_stick(input logic [15:0] xr, input logic [15:0] yr,
                                   input logic [14:0] dz,
                                   output logic [16:0] ox, output logic [16:0] oy);
        longint x, y;
        longint unsigned s, lq, base, rate, num;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        s = x * x + y * y;
        ox = '0;
        oy = '0;
        if (s <= longint'(dz) * dz) return;
        lq = int_sqrt(s << 16);
        base = longint'(dz) * 256;
        if (full_scale == dz) rate = 32768;
        else if (full_scale < dz) rate = 0;
        else begin
            num = lq > base ? lq - base : 0;
            rate = num * 32768 / ((longint'(full_scale) - dz) * 256);
            if (rate > 32768) rate = 32768;
        end
        ox = scale_axis(x, rate, lq);
        oy = scale_axis(y, rate, lq);
        if (!keep_y) oy = -oy;
    endtask

    // work out the conditioned result of one poll and advance the state
    task automatic condition_poll(input poll_t p);
        cond_t c;
        logic [15:0] btn;
        logic [7:0] lt, rt;
        logic [15:0] lx, ly, rx, ry;
        logic ln, rn;
        longint sl, sr;
        btn = p.conn ? p.btn : '0;
        lt = p.conn ? p.lt : '0;
        rt = p.conn ? p.rt : '0;
        lx = p.conn ? p.lx : '0;
        ly = p.conn ? p.ly : '0;
        rx = p.conn ? p.rx : '0;
        ry = p.conn ? p.ry : '0;
        ln = p.conn && (lt >= (lt_down ? release_lvl : press_lvl));
        rn = p.conn && (rt >= (rt_down ? release_lvl : press_lvl));
        c.held = btn;
        c.pushed = btn & ~prev_btn;
        c.released = ~btn & prev_btn;
        c.flags = {~rn & rt_down, rn & ~rt_down, rn, ~ln & lt_down, ln & ~lt_down, ln};
        c.ltl = trigger_level(lt);
        c.rtl = trigger_level(rt);
        dead_zone_stick(lx, ly, dz_l, c.lxo, c.lyo);
        dead_zone_stick(rx, ry, dz_r, c.rxo, c.ryo);
        sl = longint'($signed(lx)) ** 2 + longint'($signed(ly)) ** 2;
        sr = longint'($signed(rx)) ** 2 + longint'($signed(ry)) ** 2;
        c.active = (c.pushed != 0) || sl > longint'(dz_l) * dz_l
                   || sr > longint'(dz_r) * dz_r
                   || lt > release_lvl || rt > release_lvl;
        expected_results.push_back(c);
        prev_btn = btn;
        lt_down = ln;
        rt_down = rn;
    endtask

    task automatic report(input string what, input logic [31:0] g, input logic [31:0] e);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, g, e, $realtime);
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver: present queued polls, hold each until accepted
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                condition_poll(cur);
                in_gap = gap_length();
            end
            if (!(in_valid && !in_ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (polls.size() > 0) begin
                    cur <= polls.pop_front();
                    in_valid <= 1'b1;
                end
                else in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat against the oldest expectation
    always @(posedge clk) begin
        cond_t e;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) report("unexpected beat", 0, 0);
                else begin
                    e = expected_results.pop_front();
                    if (got.held !== e.held) report("buttons_held", got.held, e.held);
                    if (got.pushed !== e.pushed) report("buttons_pushed", got.pushed, e.pushed);
                    if (got.released !== e.released)
                        report("buttons_released", got.released, e.released);
                    if (got.flags !== e.flags) report("trigger_flags", got.flags, e.flags);
                    if (got.ltl !== e.ltl) report("left_trigger_level", got.ltl, e.ltl);
                    if (got.rtl !== e.rtl) report("right_trigger_level", got.rtl, e.rtl);
                    if (got.lxo !== e.lxo) report("left_x_out", got.lxo, e.lxo);
                    if (got.lyo !== e.lyo) report("left_y_out", got.lyo, e.lyo);
                    if (got.rxo !== e.rxo) report("right_x_out", got.rxo, e.rxo);
                    if (got.ryo !== e.ryo) report("right_y_out", got.ryo, e.ryo);
                    if (got.active !== e.active) report("input_active", got.active, e.active);
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                out_gap = gap_length();
            end
        end
    end

    // watchdog: count cycles with no beat on either channel and no APB access
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else if (polls.size() > 0 || expected_results.size() > 0 || in_valid) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input gic_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        unique case (idx)
            gic_pkg::REG_LEFT_DZ:     dz_l = val[14:0];
            gic_pkg::REG_RIGHT_DZ:    dz_r = val[14:0];
            gic_pkg::REG_PRESS_LEVEL: press_lvl = val[7:0];
            gic_pkg::REG_RELEASE_LVL: release_lvl = val[7:0];
            gic_pkg::REG_FULL_SCALE:  full_scale = val[14:0];
            gic_pkg::REG_Y_KEEP_SIGN: keep_y = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (polls.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_axis();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r < 4)
            return 16'($urandom_range(0, 8000)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        return 16'($urandom);
    endfunction

    function automatic poll_t rand_poll();
        poll_t p;
        p.conn = $urandom_range(0, 9) != 0;
        p.btn = $urandom_range(0, 1) ? 16'($urandom) : (16'($urandom) & 16'h0F0F);
        p.lt = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(10, 40));
        p.rt = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(10, 40));
        p.lx = rand_axis();
        p.ly = rand_axis();
        p.rx = rand_axis();
        p.ry = rand_axis();
        return p;
    endfunction

    task automatic random_phase(input int n);
        repeat (n) polls.push_back(rand_poll());
        wait_idle();
    endtask

    initial begin
        poll_t p;
        dz_l = gic_pkg::LEFT_DZ_RESET;
        dz_r = gic_pkg::RIGHT_DZ_RESET;
        press_lvl = gic_pkg::PRESS_RESET;
        release_lvl = gic_pkg::RELEASE_RESET;
        full_scale = gic_pkg::FULL_SCALE_RESET;
        keep_y = 1'b0;
        prev_btn = '0;
        lt_down = 1'b0;
        rt_down = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, hysteresis, disconnect
        p = '{1'b1, 16'hFFFF, 8'd255, 8'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
        polls.push_back(p);
        p = '{1'b1, 16'h0000, 8'd25, 8'd30, 16'h0000, 16'h0000, 16'd9000, 16'd0};
        polls.push_back(p);
        p = '{1'b1, 16'hA5A5, 8'd19, 8'd20, 16'd7849, 16'd0, 16'h8000, 16'h8000};
        polls.push_back(p);
        p = '{1'b0, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        polls.push_back(p);
        p = '{1'b1, 16'h5A5A, 8'd30, 8'd29, 16'd5550, 16'd5550, 16'hFFFF, 16'h0001};
        polls.push_back(p);
        p = '{1'b1, 16'h0000, 8'd0, 8'd21, 16'h0000, 16'h8001, 16'd100, 16'hFF00};
        polls.push_back(p);
        random_phase(130);

        // left dead zone zero, right dead zone at maximum, full scale one, Y kept, press level zero
        write_reg(gic_pkg::REG_LEFT_DZ, 0);
        write_reg(gic_pkg::REG_RIGHT_DZ, 32767);
        write_reg(gic_pkg::REG_FULL_SCALE, 1);
        write_reg(gic_pkg::REG_Y_KEEP_SIGN, 1);
        write_reg(gic_pkg::REG_PRESS_LEVEL, 0);
        write_reg(gic_pkg::REG_RELEASE_LVL, 254);
        p = '{1'b1, 16'h0001, 8'd0, 8'd254, 16'h0001, 16'h0000, 16'h7FFF, 16'h7FFF};
        polls.push_back(p);
        p = '{1'b1, 16'h0000, 8'd0, 8'd255, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        polls.push_back(p);
        random_phase(120);

        // full scale equal to one dead zone, below the other; press level 255
        write_reg(gic_pkg::REG_LEFT_DZ, 4000);
        write_reg(gic_pkg::REG_RIGHT_DZ, 12000);
        write_reg(gic_pkg::REG_FULL_SCALE, 4000);
        write_reg(gic_pkg::REG_PRESS_LEVEL, 255);
        write_reg(gic_pkg::REG_RELEASE_LVL, 0);
        p = '{1'b1, 16'h1234, 8'd255, 8'd254, 16'd5000, 16'd0, 16'd20000, 16'd0};
        polls.push_back(p);
        random_phase(120);

        // left dead zone and full scale at maximum, right dead zone 2000, release above press
        write_reg(gic_pkg::REG_LEFT_DZ, 32767);
        write_reg(gic_pkg::REG_RIGHT_DZ, 2000);
        write_reg(gic_pkg::REG_FULL_SCALE, 32767);
        write_reg(gic_pkg::REG_PRESS_LEVEL, 100);
        write_reg(gic_pkg::REG_RELEASE_LVL, 150);
        write_reg(gic_pkg::REG_Y_KEEP_SIGN, 0);
        random_phase(120);

        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

[sim.f]
hdl/gic_pkg.sv
hdl/gic_divider.sv
hdl/gic_sqrt.sv
hdl/gamepad_input_conditioner_core.sv
hdl/gic_checker.sv
bench/tb.sv
